>>> hdl/hmi_efp_pkg.sv
package hmi_efp_pkg;

   // Fixed widths of the beat fields.
   localparam int BYTE_W      = 8;
   localparam int EVENT_W     = 4;
   localparam int COORD_W     = 16;
   localparam int CNT_OUT_W   = 32;
   localparam int PAYLOAD_MAX = 5;
   localparam int PIDX_W      = 3;

   // Frame header codes.
   localparam logic [BYTE_W-1:0] HDR_BUTTON  = 8'h65;
   localparam logic [BYTE_W-1:0] HDR_PAGE    = 8'h66;
   localparam logic [BYTE_W-1:0] HDR_TOUCH   = 8'h67;
   localparam logic [BYTE_W-1:0] HDR_SLIDER  = 8'h55;
   localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] SLIDER_MARK = 8'hAA;
   localparam logic [BYTE_W-1:0] STATE_DOWN  = 8'h01;
   localparam logic [BYTE_W-1:0] STATE_UP    = 8'h00;
   localparam logic [BYTE_W-1:0] SLIDER_ONE  = 8'h01;
   localparam logic [BYTE_W-1:0] SLIDER_TWO  = 8'h02;
   localparam logic [BYTE_W-1:0] SLIDER_INIT = 8'd20;

   // Payload lengths per header.
   localparam logic [PIDX_W-1:0] LEN_PAGE  = 3'd1;
   localparam logic [PIDX_W-1:0] LEN_TOUCH = 3'd5;
   localparam logic [PIDX_W-1:0] LEN_OTHER = 3'd3;

   // Event codes.
   localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;
   localparam logic [EVENT_W-1:0] EV_ERROR     = 4'd1;
   localparam logic [EVENT_W-1:0] EV_BTN_DOWN  = 4'd2;
   localparam logic [EVENT_W-1:0] EV_BTN_UP    = 4'd3;
   localparam logic [EVENT_W-1:0] EV_PAGE      = 4'd4;
   localparam logic [EVENT_W-1:0] EV_TOUCH     = 4'd5;
   localparam logic [EVENT_W-1:0] EV_SLIDER_L  = 4'd6;
   localparam logic [EVENT_W-1:0] EV_SLIDER_R  = 4'd7;
   localparam logic [EVENT_W-1:0] EV_NO_EVENT  = 4'd8;

   // One received byte held in the input register.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } byte_beat_type;

endpackage

>>> hdl/hmi_efp_input_reg.sv
module hmi_efp_input_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [hmi_efp_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                req_stall,
   output hmi_efp_pkg::byte_beat_type          beat,
   input  logic                                beat_stall
);

   logic                              valid_ff, valid_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]    data_ff, data_in;

   // The register is free when empty or when its beat moves on this cycle.
   assign req_stall = valid_ff && beat_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         data_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

>>> hdl/hmi_efp_parser.sv
module hmi_efp_parser #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hmi_efp_pkg::byte_beat_type            beat,
   output logic                                  beat_stall,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hmi_efp_pkg::EVENT_W-1:0]       rsp_event_res,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_page_number,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_object_id,
   output logic [hmi_efp_pkg::COORD_W-1:0]       rsp_touch_x,
   output logic [hmi_efp_pkg::COORD_W-1:0]       rsp_touch_y,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_slider_left,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_slider_right,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_current_page,
   output logic [hmi_efp_pkg::CNT_OUT_W-1:0]     rsp_frames_seen,
   output logic [hmi_efp_pkg::CNT_OUT_W-1:0]     rsp_errors_seen
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_TERM1   = 3'd2,
      PH_TERM2   = 3'd3,
      PH_TERM3   = 3'd4
   } phase_type;

   phase_type                                phase_ff, phase_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           header_ff, header_in;
   logic [hmi_efp_pkg::PIDX_W-1:0]           left_ff, left_in;
   logic [hmi_efp_pkg::PIDX_W-1:0]           index_ff, index_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           bytes_ff [hmi_efp_pkg::PAYLOAD_MAX];
   logic [hmi_efp_pkg::BYTE_W-1:0]           bytes_in [hmi_efp_pkg::PAYLOAD_MAX];
   logic [hmi_efp_pkg::BYTE_W-1:0]           page_ff, page_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           sl_left_ff, sl_left_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           sl_right_ff, sl_right_in;
   logic [COUNTER_WIDTH-1:0]                 frame_cnt_ff, frame_cnt_in;
   logic [COUNTER_WIDTH-1:0]                 error_cnt_ff, error_cnt_in;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [hmi_efp_pkg::EVENT_W-1:0]          event_ff, event_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           pnum_ff, pnum_in;
   logic [hmi_efp_pkg::BYTE_W-1:0]           obj_ff, obj_in;
   logic [hmi_efp_pkg::COORD_W-1:0]          tx_ff, tx_in;
   logic [hmi_efp_pkg::COORD_W-1:0]          ty_ff, ty_in;
   logic [hmi_efp_pkg::CNT_OUT_W-1:0]        frames_out_ff, frames_out_in;
   logic [hmi_efp_pkg::CNT_OUT_W-1:0]        errors_out_ff, errors_out_in;

   logic                                     advance;
   logic                                     is_header;
   logic [hmi_efp_pkg::BYTE_W-1:0]           b;

   assign b          = beat.data;
   assign advance    = beat.valid && !(rsp_valid_ff && rsp_stall);
   assign beat_stall = rsp_valid_ff && rsp_stall;
   assign is_header  = (b == hmi_efp_pkg::HDR_BUTTON) || (b == hmi_efp_pkg::HDR_PAGE) ||
                       (b == hmi_efp_pkg::HDR_TOUCH)  || (b == hmi_efp_pkg::HDR_SLIDER);

   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      left_in      = left_ff;
      index_in     = index_ff;
      bytes_in     = bytes_ff;
      page_in      = page_ff;
      sl_left_in   = sl_left_ff;
      sl_right_in  = sl_right_ff;
      frame_cnt_in = frame_cnt_ff;
      error_cnt_in = error_cnt_ff;
      event_in     = hmi_efp_pkg::EV_NONE;
      pnum_in      = '0;
      obj_in       = '0;
      tx_in        = '0;
      ty_in        = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (is_header) begin
               header_in = b;
               if (b == hmi_efp_pkg::HDR_PAGE) begin
                  left_in = hmi_efp_pkg::LEN_PAGE;
               end else if (b == hmi_efp_pkg::HDR_TOUCH) begin
                  left_in = hmi_efp_pkg::LEN_TOUCH;
               end else begin
                  left_in = hmi_efp_pkg::LEN_OTHER;
               end
               index_in = '0;
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in     = PH_IDLE;
               error_cnt_in = error_cnt_ff + COUNTER_WIDTH'(1);
               event_in     = hmi_efp_pkg::EV_ERROR;
            end
         end
         PH_PAYLOAD: begin
            if (left_ff != '0) begin
               if (index_ff < hmi_efp_pkg::PIDX_W'(hmi_efp_pkg::PAYLOAD_MAX)) begin
                  bytes_in[index_ff] = b;
               end
               index_in = index_ff + 3'd1;
               left_in  = left_ff - 3'd1;
               if (left_ff == 3'd1) begin
                  phase_in = PH_TERM1;
               end
            end else begin
               phase_in     = PH_IDLE;
               error_cnt_in = error_cnt_ff + COUNTER_WIDTH'(1);
               event_in     = hmi_efp_pkg::EV_ERROR;
            end
         end
         PH_TERM1, PH_TERM2: begin
            if (b == hmi_efp_pkg::TERM_BYTE) begin
               phase_in = (phase_ff == PH_TERM1) ? PH_TERM2 : PH_TERM3;
            end else begin
               phase_in     = PH_IDLE;
               error_cnt_in = error_cnt_ff + COUNTER_WIDTH'(1);
               event_in     = hmi_efp_pkg::EV_ERROR;
            end
         end
         PH_TERM3: begin
            phase_in = PH_IDLE;
            if (b == hmi_efp_pkg::TERM_BYTE) begin
               // Frame complete: count it and decode its event.
               frame_cnt_in = frame_cnt_ff + COUNTER_WIDTH'(1);
               event_in     = hmi_efp_pkg::EV_NO_EVENT;
               if (header_ff == hmi_efp_pkg::HDR_BUTTON) begin
                  if (bytes_ff[2] == hmi_efp_pkg::STATE_DOWN ||
                      bytes_ff[2] == hmi_efp_pkg::STATE_UP) begin
                     pnum_in  = bytes_ff[0];
                     obj_in   = bytes_ff[1];
                     event_in = (bytes_ff[2] == hmi_efp_pkg::STATE_DOWN) ?
                                hmi_efp_pkg::EV_BTN_DOWN : hmi_efp_pkg::EV_BTN_UP;
                  end
               end else if (header_ff == hmi_efp_pkg::HDR_PAGE) begin
                  page_in  = bytes_ff[0];
                  event_in = hmi_efp_pkg::EV_PAGE;
               end else if (header_ff == hmi_efp_pkg::HDR_TOUCH) begin
                  if (bytes_ff[4] == hmi_efp_pkg::STATE_DOWN) begin
                     tx_in    = {bytes_ff[0], bytes_ff[1]};
                     ty_in    = {bytes_ff[2], bytes_ff[3]};
                     event_in = hmi_efp_pkg::EV_TOUCH;
                  end
               end else if (header_ff == hmi_efp_pkg::HDR_SLIDER &&
                            bytes_ff[0] == hmi_efp_pkg::SLIDER_MARK) begin
                  if (bytes_ff[1] == hmi_efp_pkg::SLIDER_ONE) begin
                     sl_left_in = bytes_ff[2];
                     event_in   = hmi_efp_pkg::EV_SLIDER_L;
                  end else if (bytes_ff[1] == hmi_efp_pkg::SLIDER_TWO) begin
                     sl_right_in = bytes_ff[2];
                     event_in    = hmi_efp_pkg::EV_SLIDER_R;
                  end
               end
            end else begin
               error_cnt_in = error_cnt_ff + COUNTER_WIDTH'(1);
               event_in     = hmi_efp_pkg::EV_ERROR;
            end
         end
         default: begin
            // Unused phase codes behave like a stray byte while idle.
            phase_in     = PH_IDLE;
            error_cnt_in = error_cnt_ff + COUNTER_WIDTH'(1);
            event_in     = hmi_efp_pkg::EV_ERROR;
         end
      endcase

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   generate
      if (COUNTER_WIDTH >= hmi_efp_pkg::CNT_OUT_W) begin : g_cnt_trunc
         assign frames_out_in = frame_cnt_in[hmi_efp_pkg::CNT_OUT_W-1:0];
         assign errors_out_in = error_cnt_in[hmi_efp_pkg::CNT_OUT_W-1:0];
      end else begin : g_cnt_ext
         assign frames_out_in = {{(hmi_efp_pkg::CNT_OUT_W-COUNTER_WIDTH){1'b0}}, frame_cnt_in};
         assign errors_out_in = {{(hmi_efp_pkg::CNT_OUT_W-COUNTER_WIDTH){1'b0}}, error_cnt_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         header_ff    <= '0;
         left_ff      <= '0;
         index_ff     <= '0;
         page_ff      <= '0;
         sl_left_ff   <= hmi_efp_pkg::SLIDER_INIT;
         sl_right_ff  <= hmi_efp_pkg::SLIDER_INIT;
         frame_cnt_ff <= '0;
         error_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            header_ff    <= header_in;
            left_ff      <= left_in;
            index_ff     <= index_in;
            page_ff      <= page_in;
            sl_left_ff   <= sl_left_in;
            sl_right_ff  <= sl_right_in;
            frame_cnt_ff <= frame_cnt_in;
            error_cnt_ff <= error_cnt_in;
         end
      end
      if (advance) begin
         bytes_ff      <= bytes_in;
         event_ff      <= event_in;
         pnum_ff       <= pnum_in;
         obj_ff        <= obj_in;
         tx_ff         <= tx_in;
         ty_ff         <= ty_in;
         frames_out_ff <= frames_out_in;
         errors_out_ff <= errors_out_in;
      end
   end

   // Latched values shown with a result are the ones after its byte; they
   // only change on an accepted byte, so the live latches match.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_page_number  = pnum_ff;
   assign rsp_object_id    = obj_ff;
   assign rsp_touch_x      = tx_ff;
   assign rsp_touch_y      = ty_ff;
   assign rsp_slider_left  = sl_left_ff;
   assign rsp_slider_right = sl_right_ff;
   assign rsp_current_page = page_ff;
   assign rsp_frames_seen  = frames_out_ff;
   assign rsp_errors_seen  = errors_out_ff;

endmodule

>>> hdl/hmi_event_frame_parser.sv
// Event frame parser for the serial link of a touch screen.
// The req_ channel carries one received byte per beat (req_rx_byte); every
// accepted byte produces exactly one beat on the rsp_ channel, carrying the
// event code for that byte, the button and touch fields of a completed frame,
// and the latched page, slider positions and frame and error counters as they
// stand after that byte.
// A byte passes through an input register and then through the parser, whose
// short decode logic updates the frame state and loads the result register.
// The byte is held in the input register and its result in the result register;
// one byte per cycle is sustained while the receiver does not raise rsp_stall.
// When the receiver raises rsp_stall, the result register holds its beat, the
// parser stops, and req_stall rises once the input register is also full;
// no beat is lost or repeated.
// A synchronous reset returns the parser to idle, clears the page latch and
// both counters, sets both slider positions to 20, and empties both
// registers. The counters are COUNTER_WIDTH bits wide and wrap; the rsp_
// ports show their low 32 bits.
module hmi_event_frame_parser #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [hmi_efp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hmi_efp_pkg::EVENT_W-1:0]       rsp_event_res,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_page_number,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_object_id,
   output logic [hmi_efp_pkg::COORD_W-1:0]       rsp_touch_x,
   output logic [hmi_efp_pkg::COORD_W-1:0]       rsp_touch_y,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_slider_left,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_slider_right,
   output logic [hmi_efp_pkg::BYTE_W-1:0]        rsp_current_page,
   output logic [hmi_efp_pkg::CNT_OUT_W-1:0]     rsp_frames_seen,
   output logic [hmi_efp_pkg::CNT_OUT_W-1:0]     rsp_errors_seen
);

   hmi_efp_pkg::byte_beat_type beat;
   logic                       beat_stall;

   // Input register: holds one byte for the parser; req_stall rises when it is full and the parser stalls.
   hmi_efp_input_reg u_input_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .beat        (beat),
      .beat_stall  (beat_stall)
   );

   // Frame state machine, latches, counters and the result register.
   hmi_efp_parser #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .beat_stall       (beat_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_page_number  (rsp_page_number),
      .rsp_object_id    (rsp_object_id),
      .rsp_touch_x      (rsp_touch_x),
      .rsp_touch_y      (rsp_touch_y),
      .rsp_slider_left  (rsp_slider_left),
      .rsp_slider_right (rsp_slider_right),
      .rsp_current_page (rsp_current_page),
      .rsp_frames_seen  (rsp_frames_seen),
      .rsp_errors_seen  (rsp_errors_seen)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // The clock runs from time zero. Every block input holds a known value
   // before the first edge, and reset is high from the start.
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [hmi_efp_pkg::BYTE_W-1:0]       req_rx_byte = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [hmi_efp_pkg::EVENT_W-1:0]      rsp_event_res;
   logic [hmi_efp_pkg::BYTE_W-1:0]       rsp_page_number;
   logic [hmi_efp_pkg::BYTE_W-1:0]       rsp_object_id;
   logic [hmi_efp_pkg::COORD_W-1:0]      rsp_touch_x;
   logic [hmi_efp_pkg::COORD_W-1:0]      rsp_touch_y;
   logic [hmi_efp_pkg::BYTE_W-1:0]       rsp_slider_left;
   logic [hmi_efp_pkg::BYTE_W-1:0]       rsp_slider_right;
   logic [hmi_efp_pkg::BYTE_W-1:0]       rsp_current_page;
   logic [hmi_efp_pkg::CNT_OUT_W-1:0]    rsp_frames_seen;
   logic [hmi_efp_pkg::CNT_OUT_W-1:0]    rsp_errors_seen;

   always #4 clock = ~clock;

   hmi_event_frame_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_page_number  (rsp_page_number),
      .rsp_object_id    (rsp_object_id),
      .rsp_touch_x      (rsp_touch_x),
      .rsp_touch_y      (rsp_touch_y),
      .rsp_slider_left  (rsp_slider_left),
      .rsp_slider_right (rsp_slider_right),
      .rsp_current_page (rsp_current_page),
      .rsp_frames_seen  (rsp_frames_seen),
      .rsp_errors_seen  (rsp_errors_seen)
   );

   // One result beat, field for field as the rsp_ ports carry it.
   typedef struct packed {
      logic [hmi_efp_pkg::EVENT_W-1:0]   event_res;
      logic [hmi_efp_pkg::BYTE_W-1:0]    page_number;
      logic [hmi_efp_pkg::BYTE_W-1:0]    object_id;
      logic [hmi_efp_pkg::COORD_W-1:0]   touch_x;
      logic [hmi_efp_pkg::COORD_W-1:0]   touch_y;
      logic [hmi_efp_pkg::BYTE_W-1:0]    slider_left;
      logic [hmi_efp_pkg::BYTE_W-1:0]    slider_right;
      logic [hmi_efp_pkg::BYTE_W-1:0]    current_page;
      logic [hmi_efp_pkg::CNT_OUT_W-1:0] frames_seen;
      logic [hmi_efp_pkg::CNT_OUT_W-1:0] errors_seen;
   } event_beat_type;

   // Where the deframer stands: idle, inside the payload, or waiting for one
   // of the three terminator bytes.
   typedef enum logic [2:0] {
      PH_IDLE, PH_PAYLOAD, PH_TERM1, PH_TERM2, PH_TERM3
   } parse_phase_type;

   // The frame tracker keeps its own copy of the parser state. Every byte
   // that the block accepts is run through it, and the beat that byte must
   // produce is queued. Result beats are checked in order against that queue.
   class frame_tracker;
      parse_phase_type                   phase = PH_IDLE;
      logic [hmi_efp_pkg::BYTE_W-1:0]    header = '0;
      logic [hmi_efp_pkg::PIDX_W-1:0]    remaining = '0;
      logic [hmi_efp_pkg::PIDX_W-1:0]    index = '0;
      logic [hmi_efp_pkg::BYTE_W-1:0]    payload [hmi_efp_pkg::PAYLOAD_MAX];
      logic [hmi_efp_pkg::BYTE_W-1:0]    page = '0;
      logic [hmi_efp_pkg::BYTE_W-1:0]    slider_l = hmi_efp_pkg::SLIDER_INIT;
      logic [hmi_efp_pkg::BYTE_W-1:0]    slider_r = hmi_efp_pkg::SLIDER_INIT;
      logic [hmi_efp_pkg::CNT_OUT_W-1:0] frames = '0;
      logic [hmi_efp_pkg::CNT_OUT_W-1:0] errors = '0;
      event_beat_type                    expected_beats [$];
      int                                failures = 0;

      function void note_byte(input logic [hmi_efp_pkg::BYTE_W-1:0] b);
         event_beat_type want;
         want = '0;
         if (phase == PH_IDLE && (b == hmi_efp_pkg::HDR_BUTTON ||
                                  b == hmi_efp_pkg::HDR_PAGE ||
                                  b == hmi_efp_pkg::HDR_TOUCH ||
                                  b == hmi_efp_pkg::HDR_SLIDER)) begin
            header    = b;
            remaining = (b == hmi_efp_pkg::HDR_PAGE)  ? hmi_efp_pkg::LEN_PAGE  :
                        (b == hmi_efp_pkg::HDR_TOUCH) ? hmi_efp_pkg::LEN_TOUCH :
                                                        hmi_efp_pkg::LEN_OTHER;
            index     = '0;
            phase     = PH_PAYLOAD;
            want.event_res = hmi_efp_pkg::EV_NONE;
         end else if (phase == PH_PAYLOAD && remaining != '0) begin
            // Header codes inside the payload are plain data; there is no resync.
            if (index < hmi_efp_pkg::PIDX_W'(hmi_efp_pkg::PAYLOAD_MAX)) payload[index] = b;
            index     = index + 3'd1;
            remaining = remaining - 3'd1;
            if (remaining == '0) phase = PH_TERM1;
            want.event_res = hmi_efp_pkg::EV_NONE;
         end else if (phase == PH_TERM1 && b == hmi_efp_pkg::TERM_BYTE) begin
            phase = PH_TERM2;
            want.event_res = hmi_efp_pkg::EV_NONE;
         end else if (phase == PH_TERM2 && b == hmi_efp_pkg::TERM_BYTE) begin
            phase = PH_TERM3;
            want.event_res = hmi_efp_pkg::EV_NONE;
         end else if (phase == PH_TERM3 && b == hmi_efp_pkg::TERM_BYTE) begin
            // A complete frame is always counted, even when it raises no event.
            phase  = PH_IDLE;
            frames = frames + 32'd1;
            want.event_res = hmi_efp_pkg::EV_NO_EVENT;
            if (header == hmi_efp_pkg::HDR_BUTTON) begin
               if (payload[2] == hmi_efp_pkg::STATE_DOWN ||
                   payload[2] == hmi_efp_pkg::STATE_UP) begin
                  want.page_number = payload[0];
                  want.object_id   = payload[1];
                  want.event_res   = (payload[2] == hmi_efp_pkg::STATE_DOWN) ?
                                     hmi_efp_pkg::EV_BTN_DOWN : hmi_efp_pkg::EV_BTN_UP;
               end
            end else if (header == hmi_efp_pkg::HDR_PAGE) begin
               page = payload[0];
               want.event_res = hmi_efp_pkg::EV_PAGE;
            end else if (header == hmi_efp_pkg::HDR_TOUCH) begin
               if (payload[4] == hmi_efp_pkg::STATE_DOWN) begin
                  want.touch_x   = {payload[0], payload[1]};
                  want.touch_y   = {payload[2], payload[3]};
                  want.event_res = hmi_efp_pkg::EV_TOUCH;
               end
            end else if (payload[0] == hmi_efp_pkg::SLIDER_MARK) begin
               if (payload[1] == hmi_efp_pkg::SLIDER_ONE) begin
                  slider_l = payload[2];
                  want.event_res = hmi_efp_pkg::EV_SLIDER_L;
               end else if (payload[1] == hmi_efp_pkg::SLIDER_TWO) begin
                  slider_r = payload[2];
                  want.event_res = hmi_efp_pkg::EV_SLIDER_R;
               end
            end
         end else begin
            // Stray byte while idle or a bad terminator: drop it and start over.
            phase  = PH_IDLE;
            errors = errors + 32'd1;
            want.event_res = hmi_efp_pkg::EV_ERROR;
         end
         want.slider_left  = slider_l;
         want.slider_right = slider_r;
         want.current_page = page;
         want.frames_seen  = frames;
         want.errors_seen  = errors;
         expected_beats.push_back(want);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_beat(input event_beat_type got);
         event_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with no byte outstanding: event_res %0h", got.event_res);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            compare_field("event_res",    32'(want.event_res),    32'(got.event_res));
            compare_field("page_number",  32'(want.page_number),  32'(got.page_number));
            compare_field("object_id",    32'(want.object_id),    32'(got.object_id));
            compare_field("touch_x",      32'(want.touch_x),      32'(got.touch_x));
            compare_field("touch_y",      32'(want.touch_y),      32'(got.touch_y));
            compare_field("slider_left",  32'(want.slider_left),  32'(got.slider_left));
            compare_field("slider_right", 32'(want.slider_right), 32'(got.slider_right));
            compare_field("current_page", 32'(want.current_page), 32'(got.current_page));
            compare_field("frames_seen",  want.frames_seen,       got.frames_seen);
            compare_field("errors_seen",  want.errors_seen,       got.errors_seen);
         end
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction
   endclass

   frame_tracker tracker = new;

   // Bytes waiting to go out on the req_ channel, and a count of those accepted.
   logic [hmi_efp_pkg::BYTE_W-1:0] tx_bytes [$];
   int                             bytes_sent = 0;

   // When quiet is set, neither side idles. A long-hold request makes the
   // receiver stall for a long run of cycles, counted in its own process.
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   // Offers one byte and returns once it has been accepted. About 38 of a
   // hundred beats are preceded by one or more idle cycles unless quiet is set.
   // req_stall is read right after the edge, so it is the value the block
   // presented at that edge.
   task automatic send_byte(input logic [hmi_efp_pkg::BYTE_W-1:0] b);
      while (!quiet && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_queued();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   // Mostly one of two legal values, sometimes any byte at all, so both the
   // event paths and the no-event paths of a frame get exercised.
   function automatic logic [hmi_efp_pkg::BYTE_W-1:0] pick_byte(
         input logic [hmi_efp_pkg::BYTE_W-1:0] a,
         input logic [hmi_efp_pkg::BYTE_W-1:0] b);
      int r;
      r = $urandom_range(9);
      if (r < 4) return a;
      if (r < 8) return b;
      return hmi_efp_pkg::BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [hmi_efp_pkg::BYTE_W-1:0] any_byte();
      return hmi_efp_pkg::BYTE_W'($urandom_range(255));
   endfunction

   // Queues one well-formed frame of a random kind with random content.
   function automatic void queue_random_frame();
      logic [hmi_efp_pkg::BYTE_W-1:0] body [$];
      case ($urandom_range(3))
         0: begin
            tx_bytes.push_back(hmi_efp_pkg::HDR_BUTTON);
            body = '{any_byte(), any_byte(),
                     pick_byte(hmi_efp_pkg::STATE_DOWN, hmi_efp_pkg::STATE_UP)};
         end
         1: begin
            tx_bytes.push_back(hmi_efp_pkg::HDR_PAGE);
            body = '{any_byte()};
         end
         2: begin
            tx_bytes.push_back(hmi_efp_pkg::HDR_TOUCH);
            body = '{any_byte(), any_byte(), any_byte(), any_byte(),
                     pick_byte(hmi_efp_pkg::STATE_DOWN, hmi_efp_pkg::STATE_DOWN)};
         end
         default: begin
            tx_bytes.push_back(hmi_efp_pkg::HDR_SLIDER);
            body = '{pick_byte(hmi_efp_pkg::SLIDER_MARK, hmi_efp_pkg::SLIDER_MARK),
                     pick_byte(hmi_efp_pkg::SLIDER_ONE, hmi_efp_pkg::SLIDER_TWO),
                     any_byte()};
         end
      endcase
      foreach (body[i]) tx_bytes.push_back(body[i]);
      repeat (3) tx_bytes.push_back(hmi_efp_pkg::TERM_BYTE);
   endfunction

   // Receiver. A beat counts at an edge where rsp_valid is high and rsp_stall
   // low; both are read right after the edge, before any update of that step.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            tracker.check_beat('{event_res: rsp_event_res, page_number: rsp_page_number,
                                 object_id: rsp_object_id, touch_x: rsp_touch_x,
                                 touch_y: rsp_touch_y, slider_left: rsp_slider_left,
                                 slider_right: rsp_slider_right,
                                 current_page: rsp_current_page,
                                 frames_seen: rsp_frames_seen,
                                 errors_seen: rsp_errors_seen});
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 38);
         end
      end
   end

   // Stimulus and the end of the run.
   initial begin : stimulus
      bit held;
      bit drained;
      held    = 1'b0;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A stray 0xFF while idle is an error. Then a button
      // press with the page and id at their extremes, a page report whose
      // payload is a header code (taken as data), a touch press at one corner
      // of the coordinate range (x at its maximum, y at zero), a right slider
      // move, and finally a page frame whose first terminator is wrong.
      tx_bytes = '{hmi_efp_pkg::TERM_BYTE,
                   hmi_efp_pkg::HDR_BUTTON, 8'h00, 8'hFF, hmi_efp_pkg::STATE_DOWN,
                   hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE,
                   hmi_efp_pkg::HDR_PAGE, hmi_efp_pkg::HDR_TOUCH,
                   hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE,
                   hmi_efp_pkg::HDR_TOUCH, 8'hFF, 8'hFF, 8'h00, 8'h00,
                   hmi_efp_pkg::STATE_DOWN,
                   hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE,
                   hmi_efp_pkg::HDR_SLIDER, hmi_efp_pkg::SLIDER_MARK,
                   hmi_efp_pkg::SLIDER_TWO, 8'h00,
                   hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE, hmi_efp_pkg::TERM_BYTE,
                   hmi_efp_pkg::HDR_PAGE, 8'h12, 8'h00};
      send_queued();

      // Random part: about four of five items are well-formed frames, the
      // rest are noise bursts and frames with one terminator corrupted.
      while (bytes_sent < 930) begin
         quiet = (bytes_sent >= 400 && bytes_sent < 550);
         if (!held && bytes_sent >= 250) begin
            // The receiver holds off while bytes keep coming, so the block
            // fills up and raises req_stall.
            held = 1'b1;
            hold_request = 1'b1;
         end
         if (!drained && bytes_sent >= 650) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            while (tracker.outstanding() != 0) @(posedge clock);
         end
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6, 7: queue_random_frame();
            8: repeat ($urandom_range(1, 4)) tx_bytes.push_back(any_byte());
            default: begin
               queue_random_frame();
               tx_bytes[tx_bytes.size() - 1 - $urandom_range(2)] = any_byte();
            end
         endcase
         send_queued();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Wait for every outstanding beat, then keep watching for anything
      // the block should not be sending.
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of about a thousand bytes.
   initial begin : watchdog
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
